FILE: sv/mck_pkg.sv
// ----------------------------------------------------------------------------
// mck_pkg: shared types and tables for the Morse character keyer
// Item structs, controller/datapath command and status groups, and the
// A-Z / 0-9 element pattern lookup.
// ----------------------------------------------------------------------------
package mck_pkg;

    localparam int unsigned DIT_W   = 10;
    localparam int unsigned DUR_W   = 12;
    localparam int unsigned PAT_W   = 5;
    localparam int unsigned LEN_W   = 3;

    localparam logic [DIT_W-1:0] DIT_RESET = 10'd70;

    // input item
    typedef struct packed {
        logic [7:0] char_code;
        logic       word_end;
    } t_in_item;

    // result item
    typedef struct packed {
        logic             tone_on;
        logic [DUR_W-1:0] duration_ms;
        logic             last;
    } t_out_item;

    // interval length in dit units
    typedef enum logic [1:0] {
        SPAN_1 = 2'd0,
        SPAN_2 = 2'd1,
        SPAN_3 = 2'd2,
        SPAN_4 = 2'd3
    } t_span;

    // element pattern: first element in the MSB, 1 = dash
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] dash;
    } t_pattern;

    // controller -> datapath
    typedef struct packed {
        logic  load;
        logic  emit;
        logic  tone;
        t_span span;
        logic  last;
        logic  shift;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic has_elem;
        logic dash;
        logic word_end;
        logic out_free;
    } t_sts;

    // Morse pattern for a character; anything without one has length zero
    function automatic t_pattern code_for(input logic [7:0] ch);
        t_pattern p;
        p = '{len: 3'd0, dash: 5'b00000};
        case (ch)
            "A": p = '{3'd2, 5'b01000};
            "B": p = '{3'd4, 5'b10000};
            "C": p = '{3'd4, 5'b10100};
            "D": p = '{3'd3, 5'b10000};
            "E": p = '{3'd1, 5'b00000};
            "F": p = '{3'd4, 5'b00100};
            "G": p = '{3'd3, 5'b11000};
            "H": p = '{3'd4, 5'b00000};
            "I": p = '{3'd2, 5'b00000};
            "J": p = '{3'd4, 5'b01110};
            "K": p = '{3'd3, 5'b10100};
            "L": p = '{3'd4, 5'b01000};
            "M": p = '{3'd2, 5'b11000};
            "N": p = '{3'd2, 5'b10000};
            "O": p = '{3'd3, 5'b11100};
            "P": p = '{3'd4, 5'b01100};
            "Q": p = '{3'd4, 5'b11010};
            "R": p = '{3'd3, 5'b01000};
            "S": p = '{3'd3, 5'b00000};
            "T": p = '{3'd1, 5'b10000};
            "U": p = '{3'd3, 5'b00100};
            "V": p = '{3'd4, 5'b00010};
            "W": p = '{3'd3, 5'b01100};
            "X": p = '{3'd4, 5'b10010};
            "Y": p = '{3'd4, 5'b10110};
            "Z": p = '{3'd4, 5'b11000};
            "0": p = '{3'd5, 5'b11111};
            "1": p = '{3'd5, 5'b01111};
            "2": p = '{3'd5, 5'b00111};
            "3": p = '{3'd5, 5'b00011};
            "4": p = '{3'd5, 5'b00001};
            "5": p = '{3'd5, 5'b00000};
            "6": p = '{3'd5, 5'b10000};
            "7": p = '{3'd5, 5'b11000};
            "8": p = '{3'd5, 5'b11100};
            "9": p = '{3'd5, 5'b11110};
            default: p = '{len: 3'd0, dash: 5'b00000};
        endcase
        return p;
    endfunction

endpackage

FILE: sv/mck_dp.sv
// ----------------------------------------------------------------------------
// mck_dp: keyer datapath
// Dit length register, pattern shift register with element count, duration
// scaling and the output item register.
// ----------------------------------------------------------------------------
module mck_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [9:0]               i_cfg_data,
    input  mck_pkg::t_in_item        i_in,
    input  mck_pkg::t_cmd            i_cmd,
    output mck_pkg::t_sts            o_sts,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output mck_pkg::t_out_item       o_out
);
    import mck_pkg::*;

    logic [DIT_W-1:0] r_dit;
    logic [PAT_W-1:0] r_pat;
    logic [LEN_W-1:0] r_left;
    logic             r_word_end;
    logic             r_out_valid;
    t_out_item        r_out;

    t_pattern         w_pat;
    logic [DUR_W-1:0] w_dit_ext;
    logic [DUR_W-1:0] w_dur;

    assign w_pat     = code_for(i_in.char_code);
    assign w_dit_ext = {{(DUR_W-DIT_W){1'b0}}, r_dit};

    // dit length times one to four units, by shift and add
    always_comb begin
        case (i_cmd.span)
            SPAN_1:  w_dur = w_dit_ext;
            SPAN_2:  w_dur = w_dit_ext << 1;
            SPAN_3:  w_dur = w_dit_ext + (w_dit_ext << 1);
            SPAN_4:  w_dur = w_dit_ext << 2;
            default: w_dur = w_dit_ext;
        endcase
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dit <= DIT_RESET;
        end else if (i_cfg_we) begin
            r_dit <= i_cfg_data;
        end
    end

    // pattern and word-end flag of the item at work
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pat      <= w_pat.dash;
            r_left     <= w_pat.len;
            r_word_end <= i_in.word_end;
        end else if (i_cmd.shift) begin
            r_pat  <= {r_pat[PAT_W-2:0], 1'b0};
            r_left <= r_left - 1'b1;
        end
    end

    // output register: takes a new item whenever it is empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.tone_on     <= i_cmd.tone;
            r_out.duration_ms <= w_dur;
            r_out.last        <= i_cmd.last;
        end
    end

    assign o_sts.has_elem = (r_left != '0);
    assign o_sts.dash     = r_pat[PAT_W-1];
    assign o_sts.word_end = r_word_end;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: sv/mck_ctrl.sv
// ----------------------------------------------------------------------------
// mck_ctrl: keyer controller
// Walks one character through element-on, element-off, character gap and
// optional word gap, one interval per free slot of the output register.
// ----------------------------------------------------------------------------
module mck_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mck_pkg::t_sts  i_sts,
    output mck_pkg::t_cmd  o_cmd
);
    import mck_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ELEM_ON,
        ST_ELEM_OFF,
        ST_WORD_GAP
    } t_state;

    t_state r_state, n_state;
    logic   r_stall, n_stall;
    t_cmd   w_cmd;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '{load: 1'b0, emit: 1'b0, tone: 1'b0, span: SPAN_1,
                    last: 1'b0, shift: 1'b0};
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = ST_ELEM_ON;
                end
            end
            ST_ELEM_ON: begin
                if (i_sts.out_free) begin
                    w_cmd.emit = 1'b1;
                    if (i_sts.has_elem) begin
                        // dot or dash
                        w_cmd.tone = 1'b1;
                        w_cmd.span = i_sts.dash ? SPAN_3 : SPAN_1;
                        n_state    = ST_ELEM_OFF;
                    end else begin
                        // character gap closes the item unless a word ends
                        w_cmd.span = SPAN_2;
                        w_cmd.last = !i_sts.word_end;
                        n_state    = i_sts.word_end ? ST_WORD_GAP : ST_IDLE;
                    end
                end
            end
            ST_ELEM_OFF: begin
                if (i_sts.out_free) begin
                    w_cmd.emit  = 1'b1;
                    w_cmd.span  = SPAN_1;
                    w_cmd.shift = 1'b1;
                    n_state     = ST_ELEM_ON;
                end
            end
            ST_WORD_GAP: begin
                if (i_sts.out_free) begin
                    w_cmd.emit = 1'b1;
                    w_cmd.span = SPAN_4;
                    w_cmd.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_stall = (n_state != ST_IDLE);
    end

    // state and registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_in_stall = r_stall;
    assign o_cmd      = w_cmd;

endmodule

FILE: sv/morse_character_keyer.sv
// ----------------------------------------------------------------------------
// morse_character_keyer: Morse keyer for one character per item
// Turns a character code into tone-on/tone-off intervals with lengths in ms.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   t_in_item  (char, word end)
//   output    out        o_out_valid / i_out_stall t_out_item (tone, ms, last)
//   config    in         i_cfg_we                  i_cfg_data (dit length)
//
// The controller takes a character while idle, then emits its intervals
// one by one whenever the output register has room. It emits at most one
// interval per cycle into a single output register. Output stall holds the
// controller in place; input stall is high from the load until the last
// interval is in the output register. Reset is synchronous, active low,
// and sets the dit length to 70 ms.
// ----------------------------------------------------------------------------
module morse_character_keyer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [9:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mck_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mck_pkg::t_out_item  o_out
);
    import mck_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    mck_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // pattern, duration and output register
    mck_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
